FILE: src/tsp_pkg.sv
// shared types and constants of the timestamp text parser
package tsp_pkg;

  localparam int EPOCH_W     = 49;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [6:0] year_hi;
    logic [6:0] year_lo;
    logic [6:0] month;
    logic [6:0] day;
    logic [6:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
    logic [9:0] millis;
    logic       neg;
    logic [6:0] off_hour;
    logic [6:0] off_min;
  } tsp_fields_t;

  typedef struct packed {
    logic        ok;
    tsp_fields_t f;
  } tsp_rec_t;

  typedef struct packed {
    logic     push;
    tsp_rec_t rec;
  } tsp_push_t;

  typedef struct packed {
    logic     valid;
    tsp_rec_t rec;
  } tsp_head_t;

endpackage

FILE: src/tsp_channels.sv
// channel interfaces of the timestamp text parser
interface tsp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface tsp_res_if;
  logic                              valid;
  logic                              ready;
  logic                              valid_res;
  logic signed [tsp_pkg::EPOCH_W-1:0] epoch_ms;

  modport source (output valid, output valid_res, output epoch_ms, input ready);
  modport sink (input valid, input valid_res, input epoch_ms, output ready);
endinterface

FILE: src/tsp_front.sv
// character front end: syntax check and field capture, one character per cycle while the queue is not full
module tsp_front (
  input  logic               clk,
  input  logic               rst,
  tsp_char_if.sink           chars,
  input  logic               full,
  output tsp_pkg::tsp_push_t push
);
  import tsp_pkg::*;

  typedef enum logic [2:0] {
    PH_FIXED, PH_AFTER, PH_FRAC1, PH_FRACN, PH_OFFS, PH_END
  } phase_t;

  localparam logic [4:0] FIXED_LEN = 5'd19;
  localparam logic [4:0] OFFS_LEN  = 5'd5;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_T_UP   = 8'h54;
  localparam logic [7:0] CH_T_LO   = 8'h74;
  localparam logic [7:0] CH_Z_UP   = 8'h5A;
  localparam logic [7:0] CH_Z_LO   = 8'h7A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  phase_t      phase, phase_next;
  logic [4:0]  pos, pos_next;
  logic        err, err_next;
  logic [1:0]  fdig, fdig_next;
  tsp_fields_t fld, fld_next;

  logic [7:0] c;
  logic [3:0] dv;
  logic       dig, is_z, is_sign, fire;

  function automatic logic [6:0] acc10(logic [6:0] x, logic [3:0] d);
    return 7'(x * 7'd10) + 7'(d);
  endfunction

  assign c       = chars.char_code;
  assign dv      = c[3:0];
  assign dig     = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_z    = (c == CH_Z_UP) || (c == CH_Z_LO);
  assign is_sign = (c == CH_PLUS) || (c == CH_DASH);
  assign fire    = chars.valid && chars.ready;

  assign chars.ready = !full;

  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    err_next   = err;
    fdig_next  = fdig;
    fld_next   = fld;
    if (!err) begin
      case (phase)
        PH_FIXED: begin
          if (pos == 5'd4 || pos == 5'd7) begin
            if (c != CH_DASH) err_next = 1'b1;
          end else if (pos == 5'd13 || pos == 5'd16) begin
            if (c != CH_COLON) err_next = 1'b1;
          end else if (pos == 5'd10) begin
            if (c != CH_T_UP && c != CH_T_LO) err_next = 1'b1;
          end else if (!dig) begin
            err_next = 1'b1;
          end else if (pos < 5'd2) begin
            fld_next.year_hi = acc10(fld.year_hi, dv);
          end else if (pos < 5'd4) begin
            fld_next.year_lo = acc10(fld.year_lo, dv);
          end else if (pos < 5'd7) begin
            fld_next.month = acc10(fld.month, dv);
          end else if (pos < 5'd10) begin
            fld_next.day = acc10(fld.day, dv);
          end else if (pos < 5'd13) begin
            fld_next.hour = acc10(fld.hour, dv);
          end else if (pos < 5'd16) begin
            fld_next.minute = acc10(fld.minute, dv);
          end else begin
            fld_next.second = acc10(fld.second, dv);
          end
          pos_next = pos + 5'd1;
          if (pos_next == FIXED_LEN) begin
            phase_next = PH_AFTER;
            pos_next   = '0;
          end
        end
        PH_FRAC1, PH_FRACN: begin
          if (dig) begin
            case (fdig)
              2'd0: fld_next.millis = fld.millis + 10'(dv) * 10'd100;
              2'd1: fld_next.millis = fld.millis + 10'(dv) * 10'd10;
              2'd2: fld_next.millis = fld.millis + 10'(dv);
              default: fld_next.millis = fld.millis;
            endcase
            if (fdig != 2'd3) fdig_next = fdig + 2'd1;
            phase_next = PH_FRACN;
          end else if (phase == PH_FRAC1) begin
            err_next = 1'b1;
          end else if (is_z) begin
            phase_next = PH_END;
          end else if (is_sign) begin
            fld_next.neg = (c == CH_DASH);
            phase_next   = PH_OFFS;
            pos_next     = '0;
          end else begin
            err_next = 1'b1;
          end
        end
        PH_AFTER: begin
          if (c == CH_DOT) begin
            phase_next = PH_FRAC1;
          end else if (is_z) begin
            phase_next = PH_END;
          end else if (is_sign) begin
            fld_next.neg = (c == CH_DASH);
            phase_next   = PH_OFFS;
            pos_next     = '0;
          end else begin
            err_next = 1'b1;
          end
        end
        PH_OFFS: begin
          if (pos == 5'd2) begin
            if (c != CH_COLON) err_next = 1'b1;
          end else if (!dig) begin
            err_next = 1'b1;
          end else if (pos < 5'd2) begin
            fld_next.off_hour = acc10(fld.off_hour, dv);
          end else begin
            fld_next.off_min = acc10(fld.off_min, dv);
          end
          pos_next = pos + 5'd1;
          if (pos_next == OFFS_LEN) begin
            phase_next = PH_END;
            pos_next   = '0;
          end
        end
        default: err_next = 1'b1;
      endcase
    end
  end

  assign push.push   = fire && chars.last_char;
  assign push.rec.ok = !err_next && (phase_next == PH_END);
  assign push.rec.f  = fld_next;

  always_ff @(posedge clk) begin
    if (rst || (fire && chars.last_char)) begin
      phase <= PH_FIXED;
      pos   <= '0;
      err   <= 1'b0;
      fdig  <= '0;
      fld   <= '0;
    end else if (fire) begin
      phase <= phase_next;
      pos   <= pos_next;
      err   <= err_next;
      fdig  <= fdig_next;
      fld   <= fld_next;
    end
  end

`ifndef SYNTH
  a_pos_only_counting: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_FIXED && phase != PH_OFFS) |-> pos == '0)
    else $error("position counter set outside a counted phase");
  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (fire && chars.last_char) |=> (phase == PH_FIXED && !err && pos == '0))
    else $error("parser did not restart after the last character");
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos < FIXED_LEN)
    else $error("position counter out of range");
`endif

endmodule

FILE: src/tsp_queue.sv
// short queue of parsed records between front and back
module tsp_queue (
  input  logic               clk,
  input  logic               rst,
  input  tsp_pkg::tsp_push_t push,
  output logic               full,
  output tsp_pkg::tsp_head_t head,
  input  logic               pop
);
  import tsp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);

  tsp_rec_t         mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == DEPTH_C);
  assign head.valid = (count != '0);
  assign head.rec   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.push) mem[wr_ptr] <= push.rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      if (push.push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push.push) count <= count - CNT_W'(1);
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.push |-> !full)
    else $error("request pushed into a full queue");
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (pop && !push.push) |=> count == $past(count) - CNT_W'(1))
    else $error("queue count wrong after pop");
`endif

endmodule

FILE: src/tsp_back.sv
// back end: range checks and conversion to utc epoch milliseconds
module tsp_back (
  input  logic               clk,
  input  logic               rst,
  input  tsp_pkg::tsp_head_t head,
  output logic               pop,
  tsp_res_if.source          results
);
  import tsp_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_SUM} bstate_t;

  localparam logic [23:0] DAY_BIAS = 24'd865566;

  bstate_t state;

  logic               ok1;
  logic signed [23:0] days1;
  logic signed [12:0] mins1;
  logic [5:0]         sec1;
  logic [9:0]         ms1;

  logic               ok2;
  logic signed [48:0] prod2;
  logic signed [29:0] rest2;

  tsp_fields_t        f;
  logic               leap, adj, ok_c;
  logic [6:0]         hh, ll;
  logic [23:0]        pos_sum;
  logic [12:0]        base_m, offs_m;
  logic signed [12:0] mins_c;
  logic [5:0]         sec_c;
  logic signed [48:0] prod_c;
  logic signed [29:0] rest_c;
  logic signed [48:0] sum_c;
  logic               out_load;

  function automatic logic [4:0] month_days(logic [6:0] m, logic lp);
    case (m)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: return 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    return 5'd30;
      7'd2:                                       return lp ? 5'd29 : 5'd28;
      default:                                    return 5'd0;
    endcase
  endfunction

  // day of year counted from march
  function automatic logic [8:0] march_doy(logic [6:0] m);
    case (m)
      7'd3:    return 9'd0;
      7'd4:    return 9'd31;
      7'd5:    return 9'd61;
      7'd6:    return 9'd92;
      7'd7:    return 9'd122;
      7'd8:    return 9'd153;
      7'd9:    return 9'd184;
      7'd10:   return 9'd214;
      7'd11:   return 9'd245;
      7'd12:   return 9'd275;
      7'd1:    return 9'd306;
      7'd2:    return 9'd337;
      default: return 9'd0;
    endcase
  endfunction

  assign f   = head.rec.f;
  assign pop = (state == B_IDLE) && head.valid;

  always_comb begin
    leap = (f.year_lo[1:0] == 2'd0) && ((f.year_lo != '0) || (f.year_hi[1:0] == 2'd0));
    ok_c = head.rec.ok && (f.month >= 7'd1) && (f.month <= 7'd12) &&
           (f.day >= 7'd1) && (f.day <= 7'(month_days(f.month, leap))) &&
           (f.hour <= 7'd23) && (f.minute <= 7'd59) && (f.second <= 7'd60) &&
           (f.off_hour <= 7'd23) && (f.off_min <= 7'd59);
    adj = (f.month <= 7'd2);
    if (adj && f.year_lo == '0) begin
      hh = f.year_hi + 7'd3;
      ll = 7'd99;
    end else begin
      hh = f.year_hi + 7'd4;
      ll = f.year_lo - 7'(adj);
    end
    pos_sum = 24'(hh) * 24'd36524 + 24'(hh[6:2]) + 24'(ll) * 24'd365 + 24'(ll[6:2]) +
              24'(march_doy(f.month)) + 24'(f.day);
    base_m  = 13'(f.hour) * 13'd60 + 13'(f.minute);
    offs_m  = 13'(f.off_hour) * 13'd60 + 13'(f.off_min);
    mins_c  = f.neg ? $signed(base_m + offs_m) : $signed(base_m - offs_m);
    sec_c   = (f.second == 7'd60) ? 6'd59 : f.second[5:0];
  end

  assign prod_c = days1 * $signed(28'd86400000);
  assign rest_c = mins1 * 30'sd60000 + $signed(30'(16'(sec1) * 16'd1000)) +
                  $signed(30'(ms1));
  assign sum_c  = prod2 + 49'(rest2);

  assign out_load = (state == B_SUM) && (!results.valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      results.valid <= 1'b0;
    end else begin
      if (out_load) results.valid <= 1'b1;
      else if (results.valid && results.ready) results.valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (head.valid) begin
            ok1   <= ok_c;
            days1 <= $signed(pos_sum - DAY_BIAS);
            mins1 <= mins_c;
            sec1  <= sec_c;
            ms1   <= f.millis;
            state <= B_MUL;
          end
        end
        B_MUL: begin
          ok2   <= ok1;
          prod2 <= prod_c;
          rest2 <= rest_c;
          state <= B_SUM;
        end
        B_SUM: begin
          if (out_load) begin
            results.valid_res <= ok2;
            results.epoch_ms  <= ok2 ? sum_c : '0;
            state             <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.valid_res) |-> results.epoch_ms == '0)
    else $error("invalid result with nonzero epoch");
  a_sum_waits: assert property (@(posedge clk) disable iff (rst)
    (state == B_SUM && results.valid && !results.ready) |=> state == B_SUM)
    else $error("result overwritten while stalled");
  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == B_MUL)
    else $error("popped request did not start conversion");
`endif

endmodule

FILE: src/timestamp_text_parser.sv
// top level of the timestamp text parser
//
//   channel   dir   payload                     handshake
//   chars     in    char_code[7:0], last_char   valid/ready
//   results   out   valid_res, epoch_ms[48:0]   valid/ready
//
// one character is taken per cycle in the front end, limited only by the
// two-entry record queue, which holds chars.ready low while it is full.
// the back end converts one string in the steps check, multiply and sum, pops
// the next record only after that, and holds each result in the output register until taken.
// synchronous active-high reset clears the parser, queue and back end.
// a stalled result output backs up the queue, then chars.ready drops.
module timestamp_text_parser (
  input  logic      clk,
  input  logic      rst,
  tsp_char_if.sink  chars,
  tsp_res_if.source results
);
  import tsp_pkg::*;

  tsp_push_t push;
  tsp_head_t head;
  logic      full;
  logic      pop;

  tsp_front u_front (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .full  (full),
    .push  (push)
  );

  tsp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .head (head),
    .pop  (pop)
  );

  tsp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

endmodule
